FILE: design/bkvt_pkg.sv
// package for the bidirectional key/value table
// holds sizes, operation and status codes, and the structs shared by all modules
// no dependencies
`timescale 1ns / 1ps

package bkvt_pkg;

  localparam int CAPACITY   = 256;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int IDX_BITS   = $clog2(CAPACITY);

  // operation codes carried in the kind field
  localparam logic [2:0] KIND_INSERT       = 3'd0;
  localparam logic [2:0] KIND_FIND_KEY     = 3'd1;
  localparam logic [2:0] KIND_FIND_VALUE   = 3'd2;
  localparam logic [2:0] KIND_REMOVE_KEY   = 3'd3;
  localparam logic [2:0] KIND_REMOVE_VALUE = 3'd4;

  // result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_DUPLICATE = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic [1:0] STATUS_FULL      = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] key_in;
    logic [31:0] value_in;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] key_out;
    logic [31:0] value_out;
  } rsp_t;

  // search token that walks down the row of cells, one cell per cycle
  typedef struct packed {
    logic                  valid;
    logic                  key_hit;
    logic [IDX_BITS-1:0]   key_idx;
    logic [VALUE_BITS-1:0] key_value;
    logic                  value_hit;
    logic [IDX_BITS-1:0]   value_idx;
    logic [KEY_BITS-1:0]   value_key;
    logic                  free_hit;
    logic [IDX_BITS-1:0]   free_idx;
  } probe_t;

  // table update broadcast to every cell
  typedef struct packed {
    logic                ins;
    logic                del;
    logic [IDX_BITS-1:0] idx;
  } wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } state_t;

endpackage

FILE: design/bkvt_cell.sv
// one table entry of the bidirectional key/value table
// compares the held pair with the query and updates the passing search token
// depends on bkvt_pkg
`timescale 1ns / 1ps

module bkvt_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [bkvt_pkg::IDX_BITS-1:0]   idx,
  input  logic [bkvt_pkg::KEY_BITS-1:0]   qkey,
  input  logic [bkvt_pkg::VALUE_BITS-1:0] qvalue,
  input  bkvt_pkg::wr_t                   wr,
  input  bkvt_pkg::probe_t                probe_in,
  output bkvt_pkg::probe_t                probe_out
);

  logic                            used;
  logic [bkvt_pkg::KEY_BITS-1:0]   key;
  logic [bkvt_pkg::VALUE_BITS-1:0] value;
  bkvt_pkg::probe_t                probe_next;
  logic                            here;

  assign here = (wr.idx == idx);

  always_comb begin
    probe_next = probe_in;
    if (!probe_in.key_hit && used && key == qkey) begin
      probe_next.key_hit   = 1'b1;
      probe_next.key_idx   = idx;
      probe_next.key_value = value;
    end
    if (!probe_in.value_hit && used && value == qvalue) begin
      probe_next.value_hit = 1'b1;
      probe_next.value_idx = idx;
      probe_next.value_key = key;
    end
    // lowest free slot wins since the token starts at cell zero
    if (!probe_in.free_hit && !used) begin
      probe_next.free_hit = 1'b1;
      probe_next.free_idx = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.ins && here) begin
      key   <= qkey;
      value <= qvalue;
    end
    probe_out.key_hit   <= probe_next.key_hit;
    probe_out.key_idx   <= probe_next.key_idx;
    probe_out.key_value <= probe_next.key_value;
    probe_out.value_hit <= probe_next.value_hit;
    probe_out.value_idx <= probe_next.value_idx;
    probe_out.value_key <= probe_next.value_key;
    probe_out.free_hit  <= probe_next.free_hit;
    probe_out.free_idx  <= probe_next.free_idx;
    if (rst) begin
      used            <= 1'b0;
      probe_out.valid <= 1'b0;
    end else begin
      probe_out.valid <= probe_next.valid;
      if (wr.ins && here) begin
        used <= 1'b1;
      end else if (wr.del && here) begin
        used <= 1'b0;
      end
    end
  end

endmodule

FILE: design/bkvt_ctrl.sv
// sequencer of the bidirectional key/value table
// takes a request, launches the search token, decides the result and the table update
// depends on bkvt_pkg
`timescale 1ns / 1ps

module bkvt_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  bkvt_pkg::req_t                  req,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output bkvt_pkg::rsp_t                  rsp,
  output logic [bkvt_pkg::KEY_BITS-1:0]   qkey,
  output logic [bkvt_pkg::VALUE_BITS-1:0] qvalue,
  output bkvt_pkg::probe_t                probe_head,
  input  bkvt_pkg::probe_t                probe_tail,
  output bkvt_pkg::wr_t                   wr
);

  bkvt_pkg::state_t state, state_next;
  logic [2:0]       kind;
  logic             launch;
  bkvt_pkg::rsp_t   res;
  bkvt_pkg::rsp_t   res_next;
  logic             req_take;
  logic             rsp_load;

  assign req_take = req_valid && !req_stall;

  always_comb begin
    probe_head       = '0;
    probe_head.valid = launch;
  end

  always_comb begin
    state_next = state;
    req_stall  = 1'b1;
    rsp_load   = 1'b0;
    res_next   = '{status: bkvt_pkg::STATUS_NOT_FOUND, key_out: 32'd0, value_out: 32'd0};
    wr         = '0;
    unique case (state)
      bkvt_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          state_next = bkvt_pkg::ST_SEARCH;
        end
      end
      bkvt_pkg::ST_SEARCH: begin
        if (probe_tail.valid) begin
          state_next = bkvt_pkg::ST_DONE;
          unique case (kind) inside
            bkvt_pkg::KIND_INSERT: begin
              if (probe_tail.key_hit) begin
                res_next = '{status: bkvt_pkg::STATUS_DUPLICATE, key_out: 32'(qkey),
                             value_out: 32'(probe_tail.key_value)};
              end else if (probe_tail.value_hit) begin
                res_next = '{status: bkvt_pkg::STATUS_DUPLICATE,
                             key_out: 32'(probe_tail.value_key), value_out: 32'(qvalue)};
              end else if (!probe_tail.free_hit) begin
                res_next.status = bkvt_pkg::STATUS_FULL;
              end else begin
                res_next = '{status: bkvt_pkg::STATUS_OK, key_out: 32'(qkey),
                             value_out: 32'(qvalue)};
                wr.ins = 1'b1;
                wr.idx = probe_tail.free_idx;
              end
            end
            bkvt_pkg::KIND_FIND_KEY, bkvt_pkg::KIND_REMOVE_KEY: begin
              if (probe_tail.key_hit) begin
                res_next = '{status: bkvt_pkg::STATUS_OK, key_out: 32'(qkey),
                             value_out: 32'(probe_tail.key_value)};
                wr.del = (kind == bkvt_pkg::KIND_REMOVE_KEY);
                wr.idx = probe_tail.key_idx;
              end
            end
            bkvt_pkg::KIND_FIND_VALUE, bkvt_pkg::KIND_REMOVE_VALUE: begin
              if (probe_tail.value_hit) begin
                res_next = '{status: bkvt_pkg::STATUS_OK,
                             key_out: 32'(probe_tail.value_key), value_out: 32'(qvalue)};
                wr.del = (kind == bkvt_pkg::KIND_REMOVE_VALUE);
                wr.idx = probe_tail.value_idx;
              end
            end
            default: begin
              res_next.status = bkvt_pkg::STATUS_NOT_FOUND;
            end
          endcase
        end
      end
      bkvt_pkg::ST_DONE: begin
        // hand over once the output register is free or being emptied
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = bkvt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bkvt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bkvt_pkg::ST_IDLE;
      launch    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= req_take;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      kind   <= req.kind;
      qkey   <= bkvt_pkg::KEY_BITS'(req.key_in);
      qvalue <= bkvt_pkg::VALUE_BITS'(req.value_in);
    end
    if (state == bkvt_pkg::ST_SEARCH && probe_tail.valid) begin
      res <= res_next;
    end
    if (rsp_load) begin
      rsp <= res;
    end
  end

endmodule

FILE: design/bidirectional_key_value_table.sv
// top level of the bidirectional key/value table
// a sequencer and a row of CAPACITY entry cells; depends on bkvt_pkg, bkvt_ctrl, bkvt_cell
// ---------------------------------------------------------------------------
// Stores up to CAPACITY unique key/value pairs, searchable by key or by value.
// Request channel req_valid / req_stall / req: kind, key_in, value_in. Kinds are
// insert, find by key, find by value, remove by key, remove by value.
// Response channel rsp_valid / rsp_stall / rsp: status, key_out, value_out, one
// response per request, in request order.
// A search token enters cell zero after the request transfer and moves one
// cell per cycle, collecting the key match, value match and lowest free slot.
// The block takes one request at a time; the search token walks the whole cell
// row for each request, and the next request can be taken in the cycle in which
// rsp_valid rises.
// A finished response sits in the output register; while it is stalled the
// next request is still taken and searched, and its response waits until the
// register is free. req_stall is low only while no request is in progress.
// Reset clears every valid mark, so the table starts empty and is usable on the
// first cycle after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bidirectional_key_value_table (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  bkvt_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output bkvt_pkg::rsp_t rsp
);

  logic [bkvt_pkg::KEY_BITS-1:0]   qkey;
  logic [bkvt_pkg::VALUE_BITS-1:0] qvalue;
  bkvt_pkg::wr_t                   wr;
  bkvt_pkg::probe_t                chain [0:bkvt_pkg::CAPACITY];

  bkvt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .qkey       (qkey),
    .qvalue     (qvalue),
    .probe_head (chain[0]),
    .probe_tail (chain[bkvt_pkg::CAPACITY]),
    .wr         (wr)
  );

  for (genvar g = 0; g < bkvt_pkg::CAPACITY; g++) begin : g_cell
    bkvt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .idx       (bkvt_pkg::IDX_BITS'(g)),
      .qkey      (qkey),
      .qvalue    (qvalue),
      .wr        (wr),
      .probe_in  (chain[g]),
      .probe_out (chain[g+1])
    );
  end

endmodule

FILE: design/bkvt_checker.sv
// port checks for the bidirectional key/value table
// watches the top level ports only and is attached by the bind below; depends on bkvt_pkg
`timescale 1ns / 1ps

module bkvt_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input bkvt_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input bkvt_pkg::rsp_t rsp
);

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  // one request at a time: busy right after a transfer
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while another is in progress");

  // full and not found carry an empty pair
  a_empty_pair: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == bkvt_pkg::STATUS_FULL ||
                  rsp.status == bkvt_pkg::STATUS_NOT_FOUND)
    |-> rsp.key_out == 32'd0 && rsp.value_out == 32'd0)
    else $error("nonzero pair on a failed request");

  // a request of unknown kind is still taken: busy right after its transfer
  a_bad_kind: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req.kind > bkvt_pkg::KIND_REMOVE_VALUE
    |=> req_stall)
    else $error("request of unknown kind not held");

endmodule

bind bidirectional_key_value_table bkvt_checker u_checker (.*);
